>>> hw/rtl/gtlp_pkg.sv
package gtlp_pkg;

  // Byte codes that steer the line parser.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LOWER_I = 8'h69;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_S = 8'h73;
  localparam logic [7:0] ZERO_CHAR = 8'h30;

  // Chromosome names that map to fixed codes.
  localparam logic [15:0] CHROM_X  = 16'h0058;
  localparam logic [15:0] CHROM_Y  = 16'h0059;
  localparam logic [15:0] CHROM_MT = 16'h4D54;
  localparam logic [31:0] CHROM_X_CODE  = 32'd23;
  localparam logic [31:0] CHROM_Y_CODE  = 32'd24;
  localparam logic [31:0] CHROM_MT_CODE = 32'd0;

  // Variant id forms.
  localparam logic [31:0] ID_NONE     = 32'hFFFF_FFFF;
  localparam logic [31:0] ID_I_FLAG   = 32'h8000_0000;
  localparam logic [15:0] ALLELE_IDLE = 16'h2020;

  // Prefix kinds of the id word.
  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_I    = 2'd1;
  localparam logic [1:0] PFX_R    = 2'd2;
  localparam logic [1:0] PFX_RS   = 2'd3;

  // Word numbers on a line, counted from one.
  localparam logic [2:0] WORD_ID     = 3'd1;
  localparam logic [2:0] WORD_CHROM  = 3'd2;
  localparam logic [2:0] WORD_POS    = 3'd3;
  localparam logic [2:0] WORD_ALLELE = 3'd4;
  localparam logic [2:0] WORD_MAX    = 3'd7;

  localparam int NUM_CALLS = 27;

  // Two-character genotype calls; a call's place in this list is its code.
  localparam logic [15:0] CALL_PAIRS [NUM_CALLS] = '{
    "--", "D ", "I ", "DD", "DI", "ID", "II", "A ", "C ", "G ",
    "T ", "AA", "AC", "AG", "AT", "CA", "CC", "CG", "CT", "GA",
    "GC", "GG", "GT", "TA", "TC", "TG", "TT"
  };

  typedef struct packed {
    logic [31:0]        variant_id;
    logic signed [31:0] chrom_code;
    logic signed [31:0] base_position;
    logic [4:0]         allele_code;
  } record_t;

  // One decimal step: acc * 10 plus the sign-extended byte minus '0'.
  function automatic logic [31:0] accum_digit(input logic [31:0] acc, input logic [7:0] c);
    logic [31:0] times_ten;
    times_ten = {acc[28:0], 3'b000} + {acc[30:0], 1'b0};
    return times_ten + {{24{c[7]}}, c} - {24'd0, ZERO_CHAR};
  endfunction

  // Code of a two-character call, zero when it is not in the list.
  function automatic logic [4:0] call_code(input logic [15:0] pair);
    logic [4:0] code;
    code = 5'd0;
    for (int i = 0; i < NUM_CALLS; i++) begin
      if (pair == CALL_PAIRS[i]) begin
        code = 5'(i);
      end
    end
    return code;
  endfunction

endpackage

>>> hw/rtl/gtlp_byte_if.sv
interface gtlp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

>>> hw/rtl/gtlp_rec_if.sv
interface gtlp_rec_if;
  logic               valid;
  logic               ready;
  logic [31:0]        variant_id;
  logic signed [31:0] chrom_code;
  logic signed [31:0] base_position;
  logic [4:0]         allele_code;

  modport source (output valid, output variant_id, output chrom_code,
                  output base_position, output allele_code, input ready);
  modport sink (input valid, input variant_id, input chrom_code,
                input base_position, input allele_code, output ready);
endinterface

>>> hw/rtl/gtlp_line_state.sv
module gtlp_line_state (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       cur_byte,
  input  logic             last,
  output logic             rec_valid,
  output gtlp_pkg::record_t rec
);
  import gtlp_pkg::*;

  logic [2:0]  word_index,        word_index_next;
  logic        inside_word,       inside_word_next;
  logic        inside_comment,    inside_comment_next;
  logic [1:0]  char_in_word,      char_in_word_next;
  logic [1:0]  id_prefix_kind,    id_prefix_kind_next;
  logic [31:0] id_accum,          id_accum_next;
  logic [31:0] chrom_accum,       chrom_accum_next;
  logic [15:0] chrom_first_chars, chrom_first_chars_next;
  logic [1:0]  chrom_length,      chrom_length_next;
  logic [31:0] pos_accum,         pos_accum_next;
  logic [15:0] allele_chars,      allele_chars_next;
  logic [1:0]  allele_length,     allele_length_next;

  logic       is_eol;
  logic       is_space;
  logic       line_close;
  logic [2:0] word_eff;
  logic [1:0] k;

  assign is_eol     = (cur_byte == CH_CR) || (cur_byte == CH_LF);
  assign is_space   = (cur_byte == CH_SPACE) || (cur_byte == CH_TAB) ||
                      (cur_byte == CH_FF) || (cur_byte == CH_VT);
  assign line_close = is_eol || last;

  // Word number and byte position that a word byte would get.
  assign word_eff = inside_word ? word_index :
                    ((word_index < WORD_MAX) ? word_index + 3'd1 : word_index);
  assign k        = inside_word ? char_in_word : 2'd0;

  // Per-byte update of the line state, before any end of line.
  always_comb begin
    word_index_next        = word_index;
    inside_word_next       = inside_word;
    inside_comment_next    = inside_comment;
    char_in_word_next      = char_in_word;
    id_prefix_kind_next    = id_prefix_kind;
    id_accum_next          = id_accum;
    chrom_accum_next       = chrom_accum;
    chrom_first_chars_next = chrom_first_chars;
    chrom_length_next      = chrom_length;
    pos_accum_next         = pos_accum;
    allele_chars_next      = allele_chars;
    allele_length_next     = allele_length;

    if (!is_eol && !inside_comment) begin
      if (cur_byte == CH_HASH) begin
        inside_comment_next = 1'b1;
        inside_word_next    = 1'b0;
      end else if (is_space) begin
        inside_word_next = 1'b0;
      end else begin
        inside_word_next  = 1'b1;
        word_index_next   = word_eff;
        char_in_word_next = (k < 2'd3) ? k + 2'd1 : k;
        case (word_eff)
          WORD_ID: begin
            if (k == 2'd0) begin
              if (cur_byte == CH_LOWER_I) begin
                id_prefix_kind_next = PFX_I;
              end else if (cur_byte == CH_LOWER_R) begin
                id_prefix_kind_next = PFX_R;
              end else begin
                id_prefix_kind_next = PFX_NONE;
              end
            end else if (k == 2'd1 && id_prefix_kind == PFX_R) begin
              id_prefix_kind_next = (cur_byte == CH_LOWER_S) ? PFX_RS : PFX_NONE;
            end else if (id_prefix_kind == PFX_I || id_prefix_kind == PFX_RS) begin
              id_accum_next = accum_digit(id_accum, cur_byte);
            end
          end
          WORD_CHROM: begin
            chrom_accum_next = accum_digit(chrom_accum, cur_byte);
            if (chrom_length < 2'd2) begin
              chrom_first_chars_next = {chrom_first_chars[7:0], cur_byte};
            end
            if (chrom_length < 2'd3) begin
              chrom_length_next = chrom_length + 2'd1;
            end
          end
          WORD_POS: begin
            pos_accum_next = accum_digit(pos_accum, cur_byte);
          end
          WORD_ALLELE: begin
            if (allele_length == 2'd0) begin
              allele_chars_next = {cur_byte, CH_SPACE};
            end else if (allele_length == 2'd1) begin
              allele_chars_next = {allele_chars[15:8], cur_byte};
            end
            if (allele_length < 2'd3) begin
              allele_length_next = allele_length + 2'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Record fields from the updated state of a closing line.
  always_comb begin
    case (id_prefix_kind_next)
      PFX_I:   rec.variant_id = ID_I_FLAG | id_accum_next;
      PFX_RS:  rec.variant_id = id_accum_next;
      default: rec.variant_id = ID_NONE;
    endcase
    if (chrom_length_next == 2'd1 && chrom_first_chars_next == CHROM_X) begin
      rec.chrom_code = CHROM_X_CODE;
    end else if (chrom_length_next == 2'd1 && chrom_first_chars_next == CHROM_Y) begin
      rec.chrom_code = CHROM_Y_CODE;
    end else if (chrom_length_next == 2'd2 && chrom_first_chars_next == CHROM_MT) begin
      rec.chrom_code = CHROM_MT_CODE;
    end else begin
      rec.chrom_code = chrom_accum_next;
    end
    rec.base_position = pos_accum_next;
    rec.allele_code   = (allele_length_next > 2'd2) ? 5'd0 : call_code(allele_chars_next);
  end

  assign rec_valid = step && line_close && (word_index_next >= WORD_ALLELE) &&
                     (rec.variant_id != 32'd0);

  // State registers; an ending line returns everything to its idle value.
  always_ff @(posedge clk) begin
    if (rst || (step && line_close)) begin
      word_index        <= 3'd0;
      inside_word       <= 1'b0;
      inside_comment    <= 1'b0;
      char_in_word      <= 2'd0;
      id_prefix_kind    <= PFX_NONE;
      id_accum          <= 32'd0;
      chrom_accum       <= 32'd0;
      chrom_first_chars <= 16'd0;
      chrom_length      <= 2'd0;
      pos_accum         <= 32'd0;
      allele_chars      <= ALLELE_IDLE;
      allele_length     <= 2'd0;
    end else if (step) begin
      word_index        <= word_index_next;
      inside_word       <= inside_word_next;
      inside_comment    <= inside_comment_next;
      char_in_word      <= char_in_word_next;
      id_prefix_kind    <= id_prefix_kind_next;
      id_accum          <= id_accum_next;
      chrom_accum       <= chrom_accum_next;
      chrom_first_chars <= chrom_first_chars_next;
      chrom_length      <= chrom_length_next;
      pos_accum         <= pos_accum_next;
      allele_chars      <= allele_chars_next;
      allele_length     <= allele_length_next;
    end
  end

endmodule

>>> hw/rtl/gtlp_out_reg.sv
module gtlp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  gtlp_pkg::record_t rec,
  output logic              space,
  gtlp_rec_if.source        records
);
  import gtlp_pkg::*;

  logic    full;
  record_t held;

  // The register can take a record when empty or when its record leaves now.
  assign space = !full || records.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (space) begin
      full <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      held <= rec;
    end
  end

  assign records.valid         = full;
  assign records.variant_id    = held.variant_id;
  assign records.chrom_code    = held.chrom_code;
  assign records.base_position = held.base_position;
  assign records.allele_code   = held.allele_code;

endmodule

>>> hw/rtl/genotype_text_line_parser.sv
// A line's closing byte is held in the input stage, its record then in the output register.
// One byte per cycle is taken while the record output does not stall.
// A stalled record output holds the byte stage, which then holds the input.
// Reset (rst, synchronous, active high) empties both stages and returns the line
// state to its idle value; no clearing pass is needed.
module genotype_text_line_parser (
  input  logic        clk,
  input  logic        rst,
  gtlp_byte_if.sink   bytes,
  gtlp_rec_if.source  records
);
  import gtlp_pkg::*;

  logic       in_full;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       space;
  logic       step;
  logic       rec_valid;
  record_t    rec;

  assign step        = in_full && space;
  assign bytes.ready = !in_full || space;

  // Input stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (bytes.ready) begin
      in_full <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte_q <= bytes.in_byte;
      in_last_q <= bytes.end_of_input;
    end
  end

  gtlp_line_state u_line_state (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .cur_byte  (in_byte_q),
    .last      (in_last_q),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  gtlp_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (rec_valid),
    .rec     (rec),
    .space   (space),
    .records (records)
  );

  // An empty output register never holds back the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !records.valid |-> bytes.ready)
    else $error("input stalled with an empty output register");

  // Records are only emitted for a nonzero id.
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    records.valid |-> (records.variant_id != 32'd0))
    else $error("record with a zero id");

  // Allele codes stay within the call list.
  a_allele_range: assert property (@(posedge clk) disable iff (rst)
    records.valid |-> (records.allele_code < 5'(NUM_CALLS)))
    else $error("allele code out of range");

  // A new record needs a byte in the input stage in the cycle before.
  a_record_source: assert property (@(posedge clk) disable iff (rst)
    (records.valid && !$past(records.valid)) |-> $past(in_full))
    else $error("record without a byte behind it");

endmodule

>>> bench/gtlp_record_checker.sv
`timescale 1ns / 1ps
module gtlp_record_checker (
  input  logic clk,
  input  logic rst,
  gtlp_byte_if bytes,
  gtlp_rec_if  records,
  output int   mismatch_count,
  output int   open_records
);
  import gtlp_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int CALL_SLOTS  = 28;
  localparam int CALL_CODES  = 27;

  // Two-character calls, packed from the left; the trailing blank pair maps back to code zero.
  localparam logic [8*2*CALL_SLOTS-1:0] CALL_TEXT =
    "--D I DDDIIDIIA C G T AAACAGATCACCCGCTGAGCGGGTTATCTGTT  ";

  // Per-line parse state of the predictor.
  logic [2:0]  words_seen;
  logic        in_word;
  logic        in_comment;
  logic [1:0]  word_pos;
  logic [1:0]  id_kind;
  logic [31:0] id_sum;
  logic [31:0] chrom_sum;
  logic [15:0] chrom_head;
  logic [1:0]  chrom_len;
  logic [31:0] pos_sum;
  logic [15:0] call_pair;
  logic [1:0]  call_len;

  record_t pending_records[$];
  int      records_seen;

  // One decimal step over any byte, digit or not, wrapping at 32 bits.
  function automatic logic [31:0] decimal_step(input logic [31:0] acc, input logic [7:0] c);
    return acc * 32'd10 + {{24{c[7]}}, c} - {24'd0, ZERO_CHAR};
  endfunction

  // The last matching slot wins; words longer than two bytes have no code.
  function automatic logic [4:0] lookup_call(input logic [15:0] pair, input logic [1:0] len);
    int hit;
    hit = 0;
    for (int i = 0; i < CALL_SLOTS; i++) begin
      if (CALL_TEXT[8*2*CALL_SLOTS-1 - 16*i -: 16] == pair) begin
        hit = i;
      end
    end
    if (len > 2'd2) begin
      hit = 0;
    end
    return 5'(hit % CALL_CODES);
  endfunction

  function automatic void clear_line();
    words_seen = '0;
    in_word    = 1'b0;
    in_comment = 1'b0;
    word_pos   = '0;
    id_kind    = PFX_NONE;
    id_sum     = '0;
    chrom_sum  = '0;
    chrom_head = '0;
    chrom_len  = '0;
    pos_sum    = '0;
    call_pair  = ALLELE_IDLE;
    call_len   = '0;
  endfunction

  // A line with four or more words yields a record unless its id comes out as zero.
  task automatic close_line(output bit made, output record_t rec);
    logic [31:0] id;
    made = 1'b0;
    rec  = '0;
    if (words_seen >= WORD_ALLELE) begin
      case (id_kind)
        PFX_I:   id = ID_I_FLAG | id_sum;
        PFX_RS:  id = id_sum;
        default: id = ID_NONE;
      endcase
      rec.variant_id = id;
      if (chrom_len == 2'd1 && chrom_head == CHROM_X) begin
        rec.chrom_code = CHROM_X_CODE;
      end else if (chrom_len == 2'd1 && chrom_head == CHROM_Y) begin
        rec.chrom_code = CHROM_Y_CODE;
      end else if (chrom_len == 2'd2 && chrom_head == CHROM_MT) begin
        rec.chrom_code = CHROM_MT_CODE;
      end else begin
        rec.chrom_code = chrom_sum;
      end
      rec.base_position = pos_sum;
      rec.allele_code   = lookup_call(call_pair, call_len);
      made = (id != 32'd0);
    end
    clear_line();
  endtask

  // Fold one word byte into the field that its word number selects.
  task automatic take_word_byte(input logic [7:0] c);
    if (!in_word) begin
      in_word  = 1'b1;
      word_pos = '0;
      if (words_seen < WORD_MAX) begin
        words_seen = words_seen + 3'd1;
      end
    end
    case (words_seen)
      WORD_ID: begin
        if (word_pos == 2'd0) begin
          id_kind = (c == CH_LOWER_I) ? PFX_I : (c == CH_LOWER_R) ? PFX_R : PFX_NONE;
        end else if (word_pos == 2'd1 && id_kind == PFX_R) begin
          id_kind = (c == CH_LOWER_S) ? PFX_RS : PFX_NONE;
        end else if (id_kind == PFX_I || id_kind == PFX_RS) begin
          id_sum = decimal_step(id_sum, c);
        end
      end
      WORD_CHROM: begin
        chrom_sum = decimal_step(chrom_sum, c);
        if (chrom_len < 2'd2) begin
          chrom_head = {chrom_head[7:0], c};
        end
        if (chrom_len < 2'd3) begin
          chrom_len = chrom_len + 2'd1;
        end
      end
      WORD_POS: begin
        pos_sum = decimal_step(pos_sum, c);
      end
      WORD_ALLELE: begin
        if (call_len == 2'd0) begin
          call_pair = {c, CH_SPACE};
        end else if (call_len == 2'd1) begin
          call_pair = {call_pair[15:8], c};
        end
        if (call_len < 2'd3) begin
          call_len = call_len + 2'd1;
        end
      end
      default: ;
    endcase
    if (word_pos < 2'd3) begin
      word_pos = word_pos + 2'd1;
    end
  endtask

  // Advance the line state by one accepted byte and queue any record it closes.
  task automatic parse_byte(input logic [7:0] c, input logic last);
    bit      made;
    record_t rec;
    made = 1'b0;
    if (c == CH_CR || c == CH_LF) begin
      close_line(made, rec);
    end else if (!in_comment) begin
      if (c == CH_HASH) begin
        in_comment = 1'b1;
        in_word    = 1'b0;
      end else if (c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT) begin
        in_word = 1'b0;
      end else begin
        take_word_byte(c);
      end
    end
    if (last) begin
      if (!made) begin
        close_line(made, rec);
      end else begin
        clear_line();
      end
    end
    if (made) begin
      pending_records.insert(pending_records.size(), rec);
    end
  endtask

  function automatic void note_mismatch(input string what, input record_t want,
                                        input record_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("record %0d, %s: expected id=%h chrom=%0d pos=%0d allele=%0d",
               records_seen, what, want.variant_id, want.chrom_code, want.base_position,
               want.allele_code);
      $display("  got id=%h chrom=%0d pos=%0d allele=%0d",
               got.variant_id, got.chrom_code, got.base_position, got.allele_code);
    end
  endfunction

  // Compare a record transfer with the oldest expected record.
  task automatic check_record();
    record_t got;
    record_t want;
    got.variant_id    = records.variant_id;
    got.chrom_code    = records.chrom_code;
    got.base_position = records.base_position;
    got.allele_code   = records.allele_code;
    if (pending_records.size() == 0) begin
      note_mismatch("no record was due", '0, got);
    end else begin
      want = pending_records.pop_front();
      if (got.variant_id !== want.variant_id || got.chrom_code !== want.chrom_code ||
          got.base_position !== want.base_position || got.allele_code !== want.allele_code) begin
        note_mismatch("field mismatch", want, got);
      end
    end
    records_seen++;
  endtask

  // Both channels are sampled at the rising edge, before the block's outputs move.
  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      pending_records.delete();
      records_seen = 0;
      mismatch_count = 0;
      open_records <= 0;
    end else begin
      if (bytes.valid && bytes.ready) begin
        parse_byte(bytes.in_byte, bytes.end_of_input);
      end
      if (records.valid && records.ready) begin
        check_record();
      end
      open_records <= pending_records.size();
    end
  end

endmodule

>>> bench/genotype_text_line_parser_tb.sv
`timescale 1ns / 1ps
module genotype_text_line_parser_tb;
  import gtlp_pkg::*;

  localparam int PHASES       = 4;
  localparam int PHASE_BYTES  = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  // Idle percentages per phase: none, sender only, receiver only, both.
  localparam int GAP_PCT   [PHASES] = '{0, 88, 0, 33};
  localparam int STALL_PCT [PHASES] = '{0, 0, 88, 33};

  localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_FF, CH_VT};
  localparam logic [7:0] BASES  [7] = '{"A", "C", "G", "T", "D", "I", "-"};

  logic clk = 1'b0;
  logic rst;
  int   tx_gap_pct   = 0;
  int   rx_stall_pct = 0;
  bit   hold_request = 1'b0;
  int   mismatch_count;
  int   open_records;
  int   phase_sent;
  bit   eoi_last;
  logic [7:0] line_buf[$];

  gtlp_byte_if bytes_ch ();
  gtlp_rec_if  recs_ch ();

  genotype_text_line_parser dut (
    .clk(clk),
    .rst(rst),
    .bytes(bytes_ch),
    .records(recs_ch)
  );

  gtlp_record_checker rec_check (
    .clk(clk),
    .rst(rst),
    .bytes(bytes_ch),
    .records(recs_ch),
    .mismatch_count(mismatch_count),
    .open_records(open_records)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Give up long after the slowest legal run would have finished.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Record sink: random stalls, plus one long hold-off on request.
  initial begin
    recs_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        recs_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      recs_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // A byte that can sit inside a word: no blank, no line end, no comment mark.
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT ||
           c == CH_CR || c == CH_LF || c == CH_HASH) begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  // Add one byte at the end of the line buffer.
  task automatic append_byte(input logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      append_byte(s[i]);
    end
  endtask

  task automatic push_blanks();
    repeat ($urandom_range(1, 3)) begin
      append_byte(($urandom_range(9) < 7) ? CH_SPACE : BLANKS[$urandom_range(3)]);
    end
  endtask

  // Mostly decimal digits, with an odd stray byte mixed in.
  task automatic push_digits(input int n);
    repeat (n) begin
      if ($urandom_range(19) == 0) begin
        append_byte(word_char());
      end else begin
        append_byte(ZERO_CHAR + 8'($urandom_range(9)));
      end
    end
  endtask

  // Content of one word by its place on the line.
  task automatic push_word(input int slot);
    int         v;
    logic [15:0] pair;
    case (slot)
      1: begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin push_text("rs"); push_digits($urandom_range(1, 9)); end
          4: begin push_text("rs"); push_digits($urandom_range(10, 12)); end
          5: begin push_text("i"); push_digits($urandom_range(10)); end
          6: begin
            push_text("r");
            if ($urandom_range(1) == 0) begin
              append_byte(word_char());
              push_digits($urandom_range(4));
            end
          end
          7: push_digits($urandom_range(1, 8));
          8: begin push_text("rs"); push_digits($urandom_range(0, 1) * $urandom_range(1, 2)); end
          default: repeat ($urandom_range(1, 4)) append_byte(word_char());
        endcase
      end
      2: begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: begin
            v = $urandom_range(1, 22);
            if (v >= 10) begin
              append_byte(ZERO_CHAR + 8'(v / 10));
            end
            append_byte(ZERO_CHAR + 8'(v % 10));
          end
          5: push_text("X");
          6: push_text("Y");
          7: push_text("MT");
          8: begin
            case ($urandom_range(3))
              0: push_text("M");
              1: push_text("XY");
              2: push_text("MTX");
              default: push_text("x");
            endcase
          end
          default: repeat ($urandom_range(1, 4)) append_byte(word_char());
        endcase
      end
      3: begin
        case ($urandom_range(9))
          8: push_digits($urandom_range(10, 12));
          9: repeat ($urandom_range(1, 4)) append_byte(word_char());
          default: push_digits($urandom_range(1, 9));
        endcase
      end
      4: begin
        case ($urandom_range(9))
          7: append_byte(BASES[$urandom_range(6)]);
          8: repeat (3) append_byte(BASES[$urandom_range(6)]);
          9: repeat ($urandom_range(1, 2)) append_byte(word_char());
          default: begin
            pair = CALL_PAIRS[$urandom_range(NUM_CALLS - 1)];
            append_byte(pair[15:8]);
            if (pair[7:0] != CH_SPACE) begin
              append_byte(pair[7:0]);
            end
          end
        endcase
      end
      default: repeat ($urandom_range(1, 5)) append_byte(word_char());
    endcase
  endtask

  // A mostly well-formed line: words, an optional comment, a line end or none.
  task automatic build_line(output bit last_closes);
    int         n_words;
    int         cmt_at;
    bit         done;
    logic [7:0] c;
    line_buf.delete();
    if ($urandom_range(4) == 0) begin
      push_blanks();
    end
    if ($urandom_range(9) == 0) begin
      n_words = $urandom_range(3);
    end else begin
      n_words = 4 + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
    end
    cmt_at = ($urandom_range(6) == 0) ? $urandom_range(1, n_words + 1) : 0;
    done = 1'b0;
    for (int w = 1; w <= n_words + 1 && !done; w++) begin
      if (w == cmt_at) begin
        append_byte(CH_HASH);
        repeat ($urandom_range(8)) begin
          c = 8'($urandom_range(255));
          append_byte((c == CH_CR || c == CH_LF) ? CH_HASH : c);
        end
        done = 1'b1;
      end else if (w <= n_words) begin
        if (w > 1) begin
          push_blanks();
        end
        push_word(w);
      end
    end
    if ($urandom_range(3) == 0) begin
      push_blanks();
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4: append_byte(CH_LF);
      5, 6: append_byte(CH_CR);
      7, 8: begin append_byte(CH_CR); append_byte(CH_LF); end
      default: ;
    endcase
    if (line_buf.size() == 0) begin
      append_byte(CH_LF);
    end
    last_closes = ($urandom_range(9) == 0);
  endtask

  // Offer one byte, with random gaps before it, and wait for its transfer.
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_gap_pct) begin
      bytes_ch.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_ch.valid        <= 1'b1;
    bytes_ch.in_byte      <= b;
    bytes_ch.end_of_input <= last;
    @(posedge clk);
    while (!bytes_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // Send the line buffer; end_of_input also falls on a rare byte mid-line.
  task automatic send_line(input bit last_closes);
    int n;
    n = line_buf.size();
    for (int i = 0; i < n; i++) begin
      push_byte(line_buf[i], (last_closes && i == n - 1) || $urandom_range(199) == 0);
    end
    phase_sent += n;
  endtask

  // Stop offering bytes until every predicted record has been taken.
  task automatic wait_drained();
    bytes_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_records != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    rst                   <= 1'b1;
    bytes_ch.valid        <= 1'b0;
    bytes_ch.in_byte      <= '0;
    bytes_ch.end_of_input <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed lines: i prefix with MT and a one-byte call, CR LF with the empty
    // line between, r without s, a high byte that makes the call too long,
    // a prefix-only id, a zero id, every blank kind and a high byte in a comment.
    line_buf.delete();
    push_text("i7 MT 9 A");
    append_byte(CH_CR);
    append_byte(CH_LF);
    send_line(1'b0);
    line_buf.delete();
    push_text("rq Y 1 GT");
    append_byte(8'h80);
    send_line(1'b1);
    line_buf.delete();
    push_text("i X 0 --");
    append_byte(CH_LF);
    send_line(1'b1);
    line_buf.delete();
    push_text("rs12");
    append_byte(CH_TAB);
    push_text("X");
    append_byte(CH_VT);
    push_text("99");
    append_byte(CH_FF);
    push_text("TT ");
    append_byte(CH_HASH);
    append_byte(8'hFF);
    append_byte(CH_LF);
    push_text("rs0 1 1 AA");
    append_byte(CH_LF);
    send_line(1'b0);
    wait_drained();

    // Random phases; the first one also holds the record sink off for a long stretch.
    for (int p = 0; p < PHASES; p++) begin
      tx_gap_pct   = GAP_PCT[p];
      rx_stall_pct = STALL_PCT[p];
      if (p == 0) begin
        hold_request = 1'b1;
      end
      phase_sent = 0;
      while (phase_sent < PHASE_BYTES) begin
        if ($urandom_range(4) == 0) begin
          line_buf.delete();
          repeat ($urandom_range(1, 10)) append_byte(8'($urandom_range(255)));
          send_line($urandom_range(9) == 0);
        end else begin
          build_line(eoi_last);
          send_line(eoi_last);
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
